FILE: rtl/rbrd_pkg.sv
package rbrd_pkg;

    localparam int IN_DATA_W  = 296;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_IS_BOX        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_SPEED_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_SPEED_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_TIME_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_ALIGN_LIMIT    = 3'd4;

    localparam logic [23:0] RST_LINEAR_SPEED_LIMIT  = 24'd3277;
    localparam logic [23:0] RST_ANGULAR_SPEED_LIMIT = 24'd6554;
    localparam logic [23:0] RST_STILL_TIME_LIMIT    = 24'd32768;
    localparam logic [16:0] RST_FACE_ALIGN_LIMIT    = 17'd63308;

    typedef logic [2:0] status_t;
    localparam status_t ST_ACTIVE   = 3'd0;
    localparam status_t ST_NOT_FLAT = 3'd1;
    localparam status_t ST_MOVING   = 3'd2;
    localparam status_t ST_ACCUM    = 3'd3;
    localparam status_t ST_REST     = 3'd4;

    typedef struct packed {
        logic [20:0]        step_time;
        logic               activity_pending;
        logic signed [31:0] lin_vel_x;
        logic signed [31:0] lin_vel_y;
        logic signed [31:0] lin_vel_z;
        logic signed [31:0] ang_vel_x;
        logic signed [31:0] ang_vel_y;
        logic signed [31:0] ang_vel_z;
        logic signed [18:0] quat_w;
        logic signed [18:0] quat_x;
        logic signed [18:0] quat_y;
        logic signed [18:0] quat_z;
    } item_t;

    typedef struct packed {
        logic [20:0]        step_time;
        logic               activity_pending;
        logic [63:0]        lin_sq_x;
        logic [63:0]        lin_sq_y;
        logic [63:0]        lin_sq_z;
        logic [63:0]        ang_sq_x;
        logic [63:0]        ang_sq_y;
        logic [63:0]        ang_sq_z;
        logic signed [37:0] p_xy;
        logic signed [37:0] p_wz;
        logic signed [37:0] p_ww;
        logic signed [37:0] p_xx;
        logic signed [37:0] p_yy;
        logic signed [37:0] p_zz;
        logic signed [37:0] p_yz;
        logic signed [37:0] p_wx;
    } prod_t;

    typedef struct packed {
        logic [20:0] step_time;
        logic        active;
        logic        flat_ok;
        logic        still;
    } flags_t;

    typedef struct packed {
        logic [31:0] still_time;
        status_t     rest_status;
        logic        go_to_rest;
    } result_t;

    typedef struct packed {
        logic        shape_is_box;
        logic [47:0] lin_limit_sq;
        logic [47:0] ang_limit_sq;
        logic [32:0] face_limit;
    } limits_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [39:0] abs40(input logic signed [39:0] v);
        abs40 = v[39] ? 40'(-v) : 40'(v);
    endfunction

endpackage

FILE: rtl/rbrd_square_stage.sv
module rbrd_square_stage
    import rbrd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t item,
    output logic  out_valid,
    input  logic  out_ready,
    output prod_t prod
);

    logic        valid_reg;
    prod_t       prod_reg;
    prod_t       prod_next;
    logic [31:0] a_lx, a_ly, a_lz, a_ax, a_ay, a_az;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign prod      = prod_reg;

    always_comb
    begin
        a_lx = abs32(item.lin_vel_x);
        a_ly = abs32(item.lin_vel_y);
        a_lz = abs32(item.lin_vel_z);
        a_ax = abs32(item.ang_vel_x);
        a_ay = abs32(item.ang_vel_y);
        a_az = abs32(item.ang_vel_z);
        prod_next.step_time        = item.step_time;
        prod_next.activity_pending = item.activity_pending;
        prod_next.lin_sq_x = a_lx * a_lx;
        prod_next.lin_sq_y = a_ly * a_ly;
        prod_next.lin_sq_z = a_lz * a_lz;
        prod_next.ang_sq_x = a_ax * a_ax;
        prod_next.ang_sq_y = a_ay * a_ay;
        prod_next.ang_sq_z = a_az * a_az;
        prod_next.p_xy = item.quat_x * item.quat_y;
        prod_next.p_wz = item.quat_w * item.quat_z;
        prod_next.p_ww = item.quat_w * item.quat_w;
        prod_next.p_xx = item.quat_x * item.quat_x;
        prod_next.p_yy = item.quat_y * item.quat_y;
        prod_next.p_zz = item.quat_z * item.quat_z;
        prod_next.p_yz = item.quat_y * item.quat_z;
        prod_next.p_wx = item.quat_w * item.quat_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: rtl/rbrd_decide_stage.sv
module rbrd_decide_stage
    import rbrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  prod_t   prod,
    input  limits_t limits,
    output logic    out_valid,
    input  logic    out_ready,
    output flags_t  flags
);

    logic               valid_reg;
    flags_t             flags_reg;
    flags_t             flags_next;
    logic [65:0]        lin_sum;
    logic [65:0]        ang_sum;
    logic signed [39:0] up_x, up_y, up_z;
    logic               flat;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign flags     = flags_reg;

    always_comb
    begin
        lin_sum = 66'(prod.lin_sq_x) + 66'(prod.lin_sq_y) + 66'(prod.lin_sq_z);
        ang_sum = 66'(prod.ang_sq_x) + 66'(prod.ang_sq_y) + 66'(prod.ang_sq_z);
        // up components of the rotated body axes, Q.32
        up_x = (40'(prod.p_xy) + 40'(prod.p_wz)) <<< 1;
        up_y = 40'(prod.p_ww) - 40'(prod.p_xx) + 40'(prod.p_yy) - 40'(prod.p_zz);
        up_z = (40'(prod.p_yz) - 40'(prod.p_wx)) <<< 1;
        flat = (abs40(up_x) >= 40'(limits.face_limit))
            || (abs40(up_y) >= 40'(limits.face_limit))
            || (abs40(up_z) >= 40'(limits.face_limit));
        flags_next.step_time = prod.step_time;
        flags_next.active    = prod.activity_pending;
        flags_next.flat_ok   = !limits.shape_is_box || flat;
        flags_next.still     = (lin_sum < 66'(limits.lin_limit_sq))
                            && (ang_sum < 66'(limits.ang_limit_sq));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            flags_reg <= flags_next;
        end
    end

endmodule

FILE: rtl/rbrd_timer_stage.sv
module rbrd_timer_stage
    import rbrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  flags_t      flags,
    input  logic [23:0] still_time_limit,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     result
);

    logic        valid_reg;
    logic [31:0] timer_reg;
    logic [31:0] timer_next;
    result_t     result_reg;
    result_t     result_next;
    logic [32:0] sum;
    logic [31:0] sat;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        sum = 33'(timer_reg) + 33'(flags.step_time);
        sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        result_next.go_to_rest = 1'b0;
        timer_next             = 32'd0;
        if (flags.active)
        begin
            result_next.rest_status = ST_ACTIVE;
        end
        else if (!flags.flat_ok)
        begin
            result_next.rest_status = ST_NOT_FLAT;
        end
        else if (!flags.still)
        begin
            result_next.rest_status = ST_MOVING;
        end
        else if (sat >= 32'(still_time_limit))
        begin
            result_next.rest_status = ST_REST;
            result_next.go_to_rest  = 1'b1;
        end
        else
        begin
            result_next.rest_status = ST_ACCUM;
            timer_next              = sat;
        end
        result_next.still_time = timer_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            timer_reg <= 32'd0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                timer_reg <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: rtl/rigid_body_rest_detector_core.sv
// channel   direction  transaction holds
// s_axis    in         one physics tick: step, activity flag, velocities, quaternion
// m_axis    out        one decision: go_to_rest, rest_status, still_time
// cfg       in         one register write, no handshake, no read-back
//
// Four register stages (input, squares, sums and compares, timer and output);
// one tick is taken every cycle while m_axis does not stall.
// The still timer add and limit compare in the last stage is the only loop.
// rst_n clears the stage valids and the timer and loads the configuration registers with their reset values.
// A stall on m_axis fills any empty stages behind it before s_axis stops.
module rigid_body_rest_detector_core
    import rbrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // step_time[20:0], activity_pending[21], lin_vel_x/y/z[117:22],
    // ang_vel_x/y/z[213:118], quat_w/x/y/z[289:214], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // go_to_rest[0], rest_status[3:1], still_time[35:4], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic        shape_is_box_reg;
    logic [23:0] linear_speed_limit_reg;
    logic [23:0] angular_speed_limit_reg;
    logic [23:0] still_time_limit_reg;
    logic [16:0] face_align_limit_reg;
    limits_t     limits_reg;
    limits_t     limits_next;

    logic        in_valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic        sq_ready;
    logic        sq_valid;
    prod_t       prod;
    logic        dec_ready;
    logic        dec_valid;
    flags_t      flags;
    logic        tmr_ready;
    result_t     result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_is_box_reg        <= 1'b0;
            linear_speed_limit_reg  <= RST_LINEAR_SPEED_LIMIT;
            angular_speed_limit_reg <= RST_ANGULAR_SPEED_LIMIT;
            still_time_limit_reg    <= RST_STILL_TIME_LIMIT;
            face_align_limit_reg    <= RST_FACE_ALIGN_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHAPE_IS_BOX:        shape_is_box_reg        <= cfg_data[0];
                CFG_LINEAR_SPEED_LIMIT:  linear_speed_limit_reg  <= cfg_data;
                CFG_ANGULAR_SPEED_LIMIT: angular_speed_limit_reg <= cfg_data;
                CFG_STILL_TIME_LIMIT:    still_time_limit_reg    <= cfg_data;
                CFG_FACE_ALIGN_LIMIT:    face_align_limit_reg    <= cfg_data[16:0];
                default:                 ;
            endcase
        end
    end

    // squared speed limits, shifted face limit and box flag, refreshed every cycle from the registers
    always_comb
    begin
        limits_next.shape_is_box = shape_is_box_reg;
        limits_next.lin_limit_sq = linear_speed_limit_reg * linear_speed_limit_reg;
        limits_next.ang_limit_sq = angular_speed_limit_reg * angular_speed_limit_reg;
        limits_next.face_limit   = {face_align_limit_reg, 16'd0};
    end

    always_ff @(posedge clk)
    begin
        limits_reg <= limits_next;
    end

    always_comb
    begin
        item_next.step_time        = s_axis_tdata[20:0];
        item_next.activity_pending = s_axis_tdata[21];
        item_next.lin_vel_x        = s_axis_tdata[53:22];
        item_next.lin_vel_y        = s_axis_tdata[85:54];
        item_next.lin_vel_z        = s_axis_tdata[117:86];
        item_next.ang_vel_x        = s_axis_tdata[149:118];
        item_next.ang_vel_y        = s_axis_tdata[181:150];
        item_next.ang_vel_z        = s_axis_tdata[213:182];
        item_next.quat_w           = s_axis_tdata[232:214];
        item_next.quat_x           = s_axis_tdata[251:233];
        item_next.quat_y           = s_axis_tdata[270:252];
        item_next.quat_z           = s_axis_tdata[289:271];
    end

    assign s_axis_tready = !in_valid_reg || sq_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg <= item_next;
        end
    end

    rbrd_square_stage u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (sq_ready),
        .item      (item_reg),
        .out_valid (sq_valid),
        .out_ready (dec_ready),
        .prod      (prod)
    );

    rbrd_decide_stage u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (dec_ready),
        .prod      (prod),
        .limits    (limits_reg),
        .out_valid (dec_valid),
        .out_ready (tmr_ready),
        .flags     (flags)
    );

    rbrd_timer_stage u_timer (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (dec_valid),
        .in_ready         (tmr_ready),
        .flags            (flags),
        .still_time_limit (still_time_limit_reg),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .result           (result)
    );

    assign m_axis_tdata = {4'd0, result.still_time, result.rest_status, result.go_to_rest};

endmodule

FILE: rtl/rbrd_checker.sv
module rbrd_checker
    import rbrd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_rest_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == ST_REST)))
        else $error("go_to_rest disagrees with rest_status");

    a_timer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3:1] != ST_ACCUM |-> m_axis_tdata[35:4] == 32'd0)
        else $error("timer not cleared outside accumulation");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:1] == ST_ACTIVE || m_axis_tdata[3:1] == ST_NOT_FLAT
            || m_axis_tdata[3:1] == ST_MOVING || m_axis_tdata[3:1] == ST_ACCUM
            || m_axis_tdata[3:1] == ST_REST))
        else $error("undefined rest_status");

    a_no_early_result: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result during reset");

endmodule

bind rigid_body_rest_detector_core rbrd_checker u_rbrd_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rbrd_pkg::*;

    localparam int PIPE_LATENCY   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;

    // indexes past the last register; writes there must leave every register alone
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam longint VEL_MIN  = -(64'sd1 <<< 31);
    localparam longint VEL_MAX  = (64'sd1 <<< 31) - 1;
    localparam int     QUAT_MIN = -131072;
    localparam int     QUAT_MAX = 131072;
    localparam int     QUAT_ONE = 65536;
    localparam int     QUAT_HALF_TURN = 46341;
    localparam int unsigned STEP_MAX = 1048576;
    localparam logic [23:0] LIMIT_MAX = 24'hFFFFFF;
    localparam logic [16:0] FACE_MAX  = 17'd65536;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register mirror and still timer of the rest decision
    logic        cfg_box = 1'b0;
    logic [23:0] cfg_lin_lim = RST_LINEAR_SPEED_LIMIT;
    logic [23:0] cfg_ang_lim = RST_ANGULAR_SPEED_LIMIT;
    logic [23:0] cfg_time_lim = RST_STILL_TIME_LIMIT;
    logic [16:0] cfg_face_lim = RST_FACE_ALIGN_LIMIT;
    logic [31:0] timer_mirror = '0;

    item_t       tick_queue[$];
    result_t     awaited[$];
    item_t       offered;
    result_t     seen;
    result_t     want;
    int unsigned tx_idle_pct = 36;
    int unsigned rx_idle_pct = 46;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          error_count = 0;
    int          stall_cycles = 0;

    rigid_body_rest_detector_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic item_t tick(logic [20:0] step_time, logic act,
                                   longint lx, longint ly, longint lz,
                                   longint ax, longint ay, longint az,
                                   int qw, int qx, int qy, int qz);
        item_t t;
        t.step_time        = step_time;
        t.activity_pending = act;
        t.lin_vel_x        = 32'(lx);
        t.lin_vel_y        = 32'(ly);
        t.lin_vel_z        = 32'(lz);
        t.ang_vel_x        = 32'(ax);
        t.ang_vel_y        = 32'(ay);
        t.ang_vel_z        = 32'(az);
        t.quat_w           = 19'(qw);
        t.quat_x           = 19'(qx);
        t.quat_y           = 19'(qy);
        t.quat_z           = 19'(qz);
        return t;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_tick(item_t t);
        return IN_DATA_W'({t.quat_z, t.quat_y, t.quat_x, t.quat_w,
                           t.ang_vel_z, t.ang_vel_y, t.ang_vel_x,
                           t.lin_vel_z, t.lin_vel_y, t.lin_vel_x,
                           t.activity_pending, t.step_time});
    endfunction

    function automatic logic [63:0] speed_sq(longint a, longint b, longint c);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mc;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        return ma * ma + mb * mb + mc * mc;
    endfunction

    // up component of each rotated body axis, unnormalized, Q.32
    function automatic bit lies_flat(item_t t);
        longint w;
        longint x;
        longint y;
        longint z;
        longint lim;
        longint up[3];
        w = t.quat_w;
        x = t.quat_x;
        y = t.quat_y;
        z = t.quat_z;
        up[0] = 2 * (x * y + w * z);
        up[1] = w * w - x * x + y * y - z * z;
        up[2] = 2 * (y * z - w * x);
        lim = longint'(cfg_face_lim) << 16;
        foreach (up[i])
            if (((up[i] < 0) ? -up[i] : up[i]) >= lim)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic result_t rest_decision(item_t t);
        result_t     r;
        logic [32:0] sum;
        r.go_to_rest = 1'b0;
        if (t.activity_pending)
        begin
            timer_mirror  = '0;
            r.rest_status = ST_ACTIVE;
        end
        else if (cfg_box && !lies_flat(t))
        begin
            timer_mirror  = '0;
            r.rest_status = ST_NOT_FLAT;
        end
        else if (speed_sq(t.lin_vel_x, t.lin_vel_y, t.lin_vel_z)
                     < 64'(cfg_lin_lim) * 64'(cfg_lin_lim) &&
                 speed_sq(t.ang_vel_x, t.ang_vel_y, t.ang_vel_z)
                     < 64'(cfg_ang_lim) * 64'(cfg_ang_lim))
        begin
            sum = {1'b0, timer_mirror} + 33'(t.step_time);
            timer_mirror = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (timer_mirror >= 32'(cfg_time_lim))
            begin
                timer_mirror  = '0;
                r.go_to_rest  = 1'b1;
                r.rest_status = ST_REST;
            end
            else
                r.rest_status = ST_ACCUM;
        end
        else
        begin
            timer_mirror  = '0;
            r.rest_status = ST_MOVING;
        end
        r.still_time = timer_mirror;
        return r;
    endfunction

    function automatic longint signed_spread(int unsigned r);
        return longint'($urandom_range(0, 2 * r)) - longint'(r);
    endfunction

    // mostly still, some near the limit, a few anywhere in range
    function automatic longint vel_component(logic [23:0] lim, int unsigned kind);
        if (kind <= 6)
            return signed_spread(lim / 2);
        else if (kind <= 8)
            return signed_spread(lim + lim / 4 + 1);
        else
            return longint'(int'($urandom));
    endfunction

    function automatic item_t random_tick(int unsigned step_cap);
        int unsigned lin_kind;
        int unsigned ang_kind;
        int unsigned jit;
        int          q[4];
        logic [20:0] step_time;
        lin_kind = $urandom_range(0, 9);
        ang_kind = $urandom_range(0, 9);
        step_time = ($urandom_range(0, 19) == 0) ? 21'($urandom_range(0, STEP_MAX))
                                                 : 21'($urandom_range(0, step_cap));
        if ($urandom_range(0, 9) < 7)
        begin
            // axis-aligned orientations, jittered to straddle the face threshold
            case ($urandom_range(0, 4))
                0:       q = '{QUAT_ONE, 0, 0, 0};
                1:       q = '{QUAT_HALF_TURN, QUAT_HALF_TURN, 0, 0};
                2:       q = '{QUAT_HALF_TURN, 0, 0, QUAT_HALF_TURN};
                3:       q = '{0, QUAT_ONE, 0, 0};
                default: q = '{QUAT_HALF_TURN, 0, QUAT_HALF_TURN, 0};
            endcase
            jit = $urandom_range(0, 1) ? 1500 : 12000;
            foreach (q[i])
                q[i] = q[i] + int'(signed_spread(jit));
            if ($urandom_range(0, 1))
                foreach (q[i])
                    q[i] = -q[i];
        end
        else
            foreach (q[i])
                q[i] = int'($urandom_range(0, QUAT_MAX - QUAT_MIN)) + QUAT_MIN;
        return tick(step_time, $urandom_range(0, 11) == 0,
                    vel_component(cfg_lin_lim, lin_kind),
                    vel_component(cfg_lin_lim, lin_kind),
                    vel_component(cfg_lin_lim, lin_kind),
                    vel_component(cfg_ang_lim, ang_kind),
                    vel_component(cfg_ang_lim, ang_kind),
                    vel_component(cfg_ang_lim, ang_kind),
                    q[0], q[1], q[2], q[3]);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_SHAPE_IS_BOX:        cfg_box      = value[0];
            CFG_LINEAR_SPEED_LIMIT:  cfg_lin_lim  = value[23:0];
            CFG_ANGULAR_SPEED_LIMIT: cfg_ang_lim  = value[23:0];
            CFG_STILL_TIME_LIMIT:    cfg_time_lim = value[23:0];
            CFG_FACE_ALIGN_LIMIT:    cfg_face_lim = value[16:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_limits(logic box, logic [23:0] lin, logic [23:0] ang,
                                  logic [23:0] tlim, logic [16:0] face);
        write_reg(CFG_SHAPE_IS_BOX, CFG_DATA_W'(box));
        write_reg(CFG_LINEAR_SPEED_LIMIT, lin);
        write_reg(CFG_ANGULAR_SPEED_LIMIT, ang);
        write_reg(CFG_STILL_TIME_LIMIT, tlim);
        write_reg(CFG_FACE_ALIGN_LIMIT, CFG_DATA_W'(face));
    endtask

    task automatic queue_tick(item_t t);
        tick_queue.insert(tick_queue.size(), t);
    endtask

    task automatic push_random(int count, int unsigned step_cap);
        repeat (count)
            queue_tick(random_tick(step_cap));
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (tick_queue.size() != 0 || s_axis_tvalid || awaited.size() != 0);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // driver: predict at each accepted transaction, then offer the next tick or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                awaited.insert(awaited.size(), rest_decision(offered));
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the offered tick
            end
            else if (tick_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                offered = tick_queue.pop_front();
                s_axis_tdata  <= pack_tick(offered);
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: check each decision, then pick the ready level for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                // result_t packs still_time, rest_status, go_to_rest from the top down
                seen = m_axis_tdata[35:0];
                if (awaited.size() == 0)
                begin
                    $error("decision with no tick awaiting it: %h", m_axis_tdata[35:0]);
                    error_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (seen.go_to_rest !== want.go_to_rest)
                    begin
                        $error("go_to_rest: expected %0d, got %0d",
                               want.go_to_rest, seen.go_to_rest);
                        error_count++;
                    end
                    if (seen.rest_status !== want.rest_status)
                    begin
                        $error("rest_status: expected %0d, got %0d",
                               want.rest_status, seen.rest_status);
                        error_count++;
                    end
                    if (seen.still_time !== want.still_time)
                    begin
                        $error("still_time: expected %h, got %h",
                               want.still_time, seen.still_time);
                        error_count++;
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits, face check off
        queue_tick(tick(21'd0, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tick(tick(21'd0, 1'b0, 0, 0, 0, 0, 0, 0, QUAT_ONE, 0, 0, 0));
        queue_tick(tick(21'd16384, 1'b0, 0, 0, 0, 0, 0, 0, QUAT_ONE, 0, 0, 0));
        // timer lands exactly on the limit: rest and clear
        queue_tick(tick(21'd16384, 1'b0, 0, 0, 0, 0, 0, 0, QUAT_ONE, 0, 0, 0));
        queue_tick(tick(21'd100, 1'b0, 3276, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tick(tick(21'd100, 1'b0, -3277, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tick(tick(21'd100, 1'b0, VEL_MIN, VEL_MAX, VEL_MIN,
                        0, 0, 0, 0, 0, 0, 0));
        queue_tick(tick(21'd100, 1'b0, 0, 0, 0, 0, 0, 6553, 0, 0, 0, 0));
        queue_tick(tick(21'(STEP_MAX), 1'b0, 0, 0, 0, 0, -6553, 0, 0, 0, 0, 0));
        queue_tick(tick(21'd100, 1'b0, 0, 0, 0, VEL_MIN, VEL_MAX, VEL_MIN,
                        0, 0, 0, 0));
        queue_tick(tick(21'd1000, 1'b0, 1, -1, 1, 1, -1, 1,
                        QUAT_MIN, QUAT_MAX, QUAT_MIN, QUAT_MAX));
        queue_tick(tick(21'd1000, 1'b1, VEL_MAX, VEL_MAX, VEL_MAX,
                        VEL_MAX, VEL_MAX, VEL_MAX, 0, 0, 0, 0));
        wait_drained();

        write_reg(CFG_SHAPE_IS_BOX, CFG_DATA_W'(1));
        write_reg(CFG_UNUSED_LO, '0);
        write_reg(CFG_UNUSED_HI, '1);
        queue_tick(tick(21'd1000, 1'b0, 0, 0, 0, 0, 0, 0, QUAT_ONE, 0, 0, 0));
        queue_tick(tick(21'd1000, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // 45 degree tilt about x: no axis near vertical
        queue_tick(tick(21'd1000, 1'b0, 0, 0, 0, 0, 0, 0, 60547, 25080, 0, 0));
        queue_tick(tick(21'd1000, 1'b0, 0, 0, 0, 0, 0, 0,
                        QUAT_HALF_TURN, QUAT_HALF_TURN, 0, 0));
        queue_tick(tick(21'd1000, 1'b0, 0, 0, 0, 0, 0, 0,
                        QUAT_HALF_TURN, 0, 0, QUAT_HALF_TURN));
        // oversized quaternions pass unnormalized
        queue_tick(tick(21'd1000, 1'b0, 0, 0, 0, 0, 0, 0, QUAT_MAX, 0, 0, 0));
        queue_tick(tick(21'd1000, 1'b0, 0, 0, 0, 0, 0, 0,
                        QUAT_MIN, QUAT_MAX, QUAT_MIN, QUAT_MAX));
        queue_tick(tick(21'd1000, 1'b0, 0, 0, 0, 0, 0, 0, 20000, 0, 0, 0));
        queue_tick(tick(21'd1000, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_tick(tick(21'd1000, 1'b0, VEL_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        program_limits(1'b1, 24'($urandom_range(1000, 300000)),
                       24'($urandom_range(1000, 300000)),
                       24'($urandom_range(20000, 300000)),
                       17'($urandom_range(40000, 65535)));
        push_random(170, cfg_time_lim / 3 + 1);
        wait_drained();

        tx_idle_pct = 46;
        rx_idle_pct = 36;
        // widest speed limits, exact face alignment, rest on any still tick
        program_limits(1'b1, LIMIT_MAX, LIMIT_MAX, '0, FACE_MAX);
        push_random(80, 4096);
        wait_drained();

        // zero speed limits: nothing is ever still
        program_limits(1'b0, '0, '0, LIMIT_MAX, '0);
        push_random(40, STEP_MAX);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_limits(1'b1, 24'($urandom_range(1000, 300000)),
                       24'($urandom_range(1000, 300000)),
                       24'($urandom_range(20000, 300000)),
                       RST_FACE_ALIGN_LIMIT);
        push_random(100, cfg_time_lim / 3 + 1);
        // stall the output long enough for back pressure to reach the input
        hold_requests++;
        wait_drained();
        push_random(100, cfg_time_lim / 3 + 1);
        wait_drained();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
